// ===== rtl/gbcs_pkg.sv =====
// Shared types and constants for the gyro bias calibration and scaling block.
`timescale 1ns / 1ps
package gbcs_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int SENS_W      = 10;
   localparam int RATE_W      = 27;
   localparam int CAL_SAMPLES = 100;
   localparam int COUNT_W     = $clog2(CAL_SAMPLES + 1);
   localparam int SUM_W       = SAMPLE_W + $clog2(CAL_SAMPLES);
   localparam int DIFF_W      = SUM_W + 1;
   localparam int PROD_W      = DIFF_W + SENS_W;
   localparam int HALF_N      = CAL_SAMPLES / 2;

   // divide by N as a multiply by ceil(2^RECIP_SHIFT / N); exact for any dividend below 2^DVD_W
   localparam int DVD_W       = PROD_W;
   localparam int RECIP_SHIFT = DVD_W + $clog2(CAL_SAMPLES);
   localparam int RECIP_W     = DVD_W + 2;
   localparam int RECIP_LO_W  = RECIP_W / 2;
   localparam int RECIP_HI_W  = RECIP_W - RECIP_LO_W;
   localparam int ACC_W       = DVD_W + RECIP_W;

   localparam logic [RECIP_W-1:0] RECIP_N =
      RECIP_W'(((longint'(1) <<< RECIP_SHIFT) + longint'(CAL_SAMPLES) - 1) /
               longint'(CAL_SAMPLES));
   localparam logic [RECIP_LO_W-1:0] RECIP_LO = RECIP_N[RECIP_LO_W-1:0];
   localparam logic [RECIP_HI_W-1:0] RECIP_HI = RECIP_N[RECIP_W-1:RECIP_LO_W];

   localparam logic [SENS_W-1:0]        SENS_RESET = SENS_W'(70);
   localparam logic signed [RATE_W-1:0] FAIL_MDPS  = -RATE_W'(999000);

   typedef enum logic [1:0] {
      AXIS_X,
      AXIS_Y,
      AXIS_Z
   } axis_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ACCUM,
      ST_SUB,
      ST_MUL,
      ST_PREP,
      ST_DIV_LO,
      ST_DIV_HI,
      ST_STORE,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic     load;      // capture the input transaction
      logic     accum;     // add a good sample into bias sums, bump count
      logic     sub;       // raw*N - sum for the selected axis
      logic     mul;       // times sensitivity
      logic     prep;      // magnitude plus rounding offset
      logic     div_lo;    // dividend times low half of the reciprocal
      logic     div_hi;    // add dividend times high half of the reciprocal
      logic     store;     // write quotient into the axis result
      logic     out_load;  // move results into the output register
      axis_type axis;
   } cmd_type;

   typedef struct packed {
      logic calibrating;
      logic read_ok;
   } status_type;

endpackage

// ===== rtl/gbcs_ctrl.sv =====
// Sequencer: steps each transaction through calibration, the per-axis scale and divide, or the failure response.
`timescale 1ns / 1ps
module gbcs_ctrl
   import gbcs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   axis_type  axis_ff, axis_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= AXIS_X;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      axis_in   = axis_ff;
      cmd       = '0;
      cmd.axis  = axis_ff;
      req_ready = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               axis_in  = AXIS_X;
               if (status.calibrating) begin
                  state_in = ST_ACCUM;
               end else if (status.read_ok) begin
                  state_in = ST_SUB;
               end else begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_ACCUM: begin
            cmd.accum = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_SUB: begin
            cmd.sub  = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_PREP;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_DIV_LO;
         end
         ST_DIV_LO: begin
            cmd.div_lo = 1'b1;
            state_in   = ST_DIV_HI;
         end
         ST_DIV_HI: begin
            cmd.div_hi = 1'b1;
            state_in   = ST_STORE;
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            case (axis_ff)
               AXIS_X: begin
                  axis_in  = AXIS_Y;
                  state_in = ST_SUB;
               end
               AXIS_Y: begin
                  axis_in  = AXIS_Z;
                  state_in = ST_SUB;
               end
               default: begin
                  state_in = ST_OUT;
               end
            endcase
         end
         ST_OUT: begin
            // wait for the output register to drain
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/gbcs_datapath.sv =====
// Datapath: bias sums, sensitivity register, scale multiply and reciprocal divide by N.
`timescale 1ns / 1ps
module gbcs_datapath
   import gbcs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output status_type               status,
   input  logic                     req_read_ok,
   input  logic signed [SAMPLE_W-1:0] req_raw_x,
   input  logic signed [SAMPLE_W-1:0] req_raw_y,
   input  logic signed [SAMPLE_W-1:0] req_raw_z,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [SENS_W-1:0]        csr_data,
   output logic signed [RATE_W-1:0] rsp_rate_x,
   output logic signed [RATE_W-1:0] rsp_rate_y,
   output logic signed [RATE_W-1:0] rsp_rate_z,
   output logic                     rsp_read_failed
);

   localparam logic signed [DIFF_W-1:0] CAL_N = DIFF_W'(CAL_SAMPLES);

   logic [SENS_W-1:0]           sens_ff;
   logic [COUNT_W-1:0]          count_ff;
   logic signed [SUM_W-1:0]     sum_x_ff, sum_y_ff, sum_z_ff;
   logic                        ok_ff;
   logic signed [SAMPLE_W-1:0]  raw_x_ff, raw_y_ff, raw_z_ff;
   logic signed [DIFF_W-1:0]    diff_ff, diff_in;
   logic signed [PROD_W-1:0]    prod_ff;
   logic signed [PROD_W-1:0]    prod_full;
   logic                        neg_ff;
   logic [PROD_W-1:0]           mag;
   logic [DVD_W-1:0]            dvd_ff;
   logic [RECIP_HI_W-1:0]       recip_sel;
   logic [DVD_W+RECIP_HI_W-1:0] part;
   logic [ACC_W-1:0]            acc_ff;
   logic [RATE_W-1:0]           quo;
   logic signed [RATE_W-1:0]    res_x_ff, res_y_ff, res_z_ff, res_in;
   logic signed [SAMPLE_W-1:0]  raw_sel;
   logic signed [SUM_W-1:0]     sum_sel;
   logic signed [RATE_W-1:0]    rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic                        rsp_fail_ff;

   assign csr_ready          = 1'b1;
   assign status.calibrating = (count_ff < COUNT_W'(CAL_SAMPLES));
   assign status.read_ok     = req_read_ok;

   // control-side state
   always_ff @(posedge clock) begin
      if (reset) begin
         sens_ff  <= SENS_RESET;
         count_ff <= '0;
         sum_x_ff <= '0;
         sum_y_ff <= '0;
         sum_z_ff <= '0;
      end else begin
         if (csr_valid) begin
            sens_ff <= csr_data;
         end
         if (cmd.accum) begin
            count_ff <= count_ff + 1'b1;
            if (ok_ff) begin
               sum_x_ff <= sum_x_ff + SUM_W'(raw_x_ff);
               sum_y_ff <= sum_y_ff + SUM_W'(raw_y_ff);
               sum_z_ff <= sum_z_ff + SUM_W'(raw_z_ff);
            end
         end
      end
   end

   always_comb begin
      case (cmd.axis)
         AXIS_X: begin
            raw_sel = raw_x_ff;
            sum_sel = sum_x_ff;
         end
         AXIS_Y: begin
            raw_sel = raw_y_ff;
            sum_sel = sum_y_ff;
         end
         default: begin
            raw_sel = raw_z_ff;
            sum_sel = sum_z_ff;
         end
      endcase
   end

   assign diff_in   = DIFF_W'(raw_sel) * CAL_N - DIFF_W'(sum_sel);
   assign prod_full = PROD_W'(diff_ff) * PROD_W'($signed({1'b0, sens_ff}));
   assign mag       = prod_ff[PROD_W-1] ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);

   // one shared multiplier takes the reciprocal in two halves, low half first
   assign recip_sel = cmd.div_hi ? RECIP_HI : RECIP_HI_W'(RECIP_LO);
   assign part      = (DVD_W + RECIP_HI_W)'(dvd_ff) * (DVD_W + RECIP_HI_W)'(recip_sel);
   assign quo       = acc_ff[RECIP_SHIFT +: RATE_W];
   assign res_in    = neg_ff ? -$signed(quo) : $signed(quo);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ok_ff    <= req_read_ok;
         raw_x_ff <= req_raw_x;
         raw_y_ff <= req_raw_y;
         raw_z_ff <= req_raw_z;
      end
      if (cmd.sub) begin
         diff_ff <= diff_in;
      end
      if (cmd.mul) begin
         prod_ff <= prod_full;
      end
      if (cmd.prep) begin
         neg_ff <= prod_ff[PROD_W-1];
         dvd_ff <= DVD_W'(mag) + DVD_W'(HALF_N);
      end
      if (cmd.div_lo) begin
         acc_ff <= ACC_W'(part);
      end
      if (cmd.div_hi) begin
         acc_ff <= acc_ff + (ACC_W'(part) << RECIP_LO_W);
      end
      if (cmd.store) begin
         case (cmd.axis)
            AXIS_X:  res_x_ff <= res_in;
            AXIS_Y:  res_y_ff <= res_in;
            default: res_z_ff <= res_in;
         endcase
      end
      if (cmd.out_load) begin
         rsp_x_ff    <= ok_ff ? res_x_ff : FAIL_MDPS;
         rsp_y_ff    <= ok_ff ? res_y_ff : FAIL_MDPS;
         rsp_z_ff    <= ok_ff ? res_z_ff : FAIL_MDPS;
         rsp_fail_ff <= !ok_ff;
      end
   end

   assign rsp_rate_x      = rsp_x_ff;
   assign rsp_rate_y      = rsp_y_ff;
   assign rsp_rate_z      = rsp_z_ff;
   assign rsp_read_failed = rsp_fail_ff;

endmodule

// ===== rtl/gyro_bias_calibrate_and_scale.sv =====
// Top level of the gyro bias calibration and scaling block.
//
// Channels: req_ carries one three-axis raw sample plus a read-ok flag per
// transaction; rsp_ carries the scaled rates and a failure flag; csr_ writes
// the sensitivity register (millidegrees/s per count) and is always ready.
// The first 100 transactions after reset only build the bias sums and give
// no response. After that, every transaction gives one response. A good
// sample goes from accept to response valid through, per axis, one subtract,
// one multiply, one rounding prep, two reciprocal multiply steps for the
// divide by N on one shared multiplier, and a store, then the output state.
// The next transaction is accepted the cycle after the response loads. A
// failed read goes straight to the output state and answers with -999000 on
// all axes. One transaction is in flight at a time; the next is accepted
// while a response still sits in the output register. If the receiver
// stalls, the sequencer holds in its output state until the output register
// frees up. Synchronous reset clears the sums, the count and the handshake
// state, and sets the sensitivity to 70.
`timescale 1ns / 1ps
module gyro_bias_calibrate_and_scale
   import gbcs_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_read_ok,
   input  logic signed [SAMPLE_W-1:0] req_raw_x,
   input  logic signed [SAMPLE_W-1:0] req_raw_y,
   input  logic signed [SAMPLE_W-1:0] req_raw_z,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [RATE_W-1:0]   rsp_rate_x,
   output logic signed [RATE_W-1:0]   rsp_rate_y,
   output logic signed [RATE_W-1:0]   rsp_rate_z,
   output logic                       rsp_read_failed,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [SENS_W-1:0]          csr_data
);

   cmd_type    cmd;
   status_type status;

   gbcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   gbcs_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_read_ok     (req_read_ok),
      .req_raw_x       (req_raw_x),
      .req_raw_y       (req_raw_y),
      .req_raw_z       (req_raw_z),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .rsp_rate_x      (rsp_rate_x),
      .rsp_rate_y      (rsp_rate_y),
      .rsp_rate_z      (rsp_rate_z),
      .rsp_read_failed (rsp_read_failed)
   );

endmodule

// ===== tb/sv/tb_gyro_bias_calibrate_and_scale.sv =====
// Self-checking testbench for the gyro bias calibration and scaling block.
`timescale 1ns / 1ps
module tb_gyro_bias_calibrate_and_scale
   import gbcs_pkg::*;
();

   localparam int  CYCLE_LIMIT = 1000000;
   localparam int  SETTLE_CYCLES = 40;
   localparam int  PHASE_ITEMS = 100;
   localparam int  RANDOM_PHASES = 18;
   localparam logic READ_GOOD = 1'b1;
   localparam logic READ_FAIL = 1'b0;
   localparam logic signed [SAMPLE_W-1:0] RAW_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] RAW_MIN = 16'sh8000;

   typedef struct packed {
      logic signed [RATE_W-1:0] x;
      logic signed [RATE_W-1:0] y;
      logic signed [RATE_W-1:0] z;
      logic                     failed;
   } rate_set_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic                       req_read_ok = 1'b0;
   logic signed [SAMPLE_W-1:0] req_raw_x = '0;
   logic signed [SAMPLE_W-1:0] req_raw_y = '0;
   logic signed [SAMPLE_W-1:0] req_raw_z = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [RATE_W-1:0]   rsp_rate_x;
   logic signed [RATE_W-1:0]   rsp_rate_y;
   logic signed [RATE_W-1:0]   rsp_rate_z;
   logic                       rsp_read_failed;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [SENS_W-1:0]          csr_data = '0;

   // predictor state
   logic [SENS_W-1:0] sens_model = SENS_RESET;
   longint            bias_x = 0;
   longint            bias_y = 0;
   longint            bias_z = 0;
   int                cal_taken = 0;
   rate_set_type      pending_rates[$];

   int          idle_odds = 0;   // 0 disables sender gaps
   int          stall_odds = 0;  // 0 disables receiver stalls
   int unsigned errors = 0;
   int unsigned cycle_count = 0;

   gyro_bias_calibrate_and_scale uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_read_ok     (req_read_ok),
      .req_raw_x       (req_raw_x),
      .req_raw_y       (req_raw_y),
      .req_raw_z       (req_raw_z),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_rate_x      (rsp_rate_x),
      .rsp_rate_y      (rsp_rate_y),
      .rsp_rate_z      (rsp_rate_z),
      .rsp_read_failed (rsp_read_failed),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data)
   );

   initial begin
      forever begin
         #6 clock = ~clock;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // receiver back-pressure in random bursts
   initial begin
      forever begin
         @(posedge clock);
         if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // (raw*N - sum)*sens/N, rounded half away from zero, wrapped to the port width
   function automatic logic signed [RATE_W-1:0] expected_rate(
      input logic signed [SAMPLE_W-1:0] raw,
      input longint                     bias_sum
   );
      longint num;
      longint mag;
      longint q;
      num = (longint'(raw) * CAL_SAMPLES - bias_sum) * longint'(sens_model);
      mag = (num < 0) ? -num : num;
      q = (mag + CAL_SAMPLES / 2) / CAL_SAMPLES;
      if (num < 0) q = -q;
      return q[RATE_W-1:0];
   endfunction

   task automatic predict_sample(input logic ok, input logic signed [SAMPLE_W-1:0] x, y, z);
      rate_set_type want;
      if (cal_taken < CAL_SAMPLES) begin
         if (ok) begin
            bias_x += x;
            bias_y += y;
            bias_z += z;
         end
         cal_taken++;
      end else begin
         if (!ok) begin
            want = '{x: FAIL_MDPS, y: FAIL_MDPS, z: FAIL_MDPS, failed: 1'b1};
         end else begin
            want.x = expected_rate(x, bias_x);
            want.y = expected_rate(y, bias_y);
            want.z = expected_rate(z, bias_z);
            want.failed = 1'b0;
         end
         pending_rates.push_back(want);
      end
   endtask

   // valid stays high after acceptance; the next send or settle decides
   task automatic send_sample(input logic ok, input logic signed [SAMPLE_W-1:0] x, y, z);
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_read_ok <= ok;
      req_raw_x   <= x;
      req_raw_y   <= y;
      req_raw_z   <= z;
      do @(posedge clock); while (!req_ready);
      predict_sample(ok, x, y, z);
   endtask

   // drop valid, drain the responses, then let an in-flight transaction finish
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_rates.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_sensitivity(input logic [SENS_W-1:0] value);
      settle();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      sens_model = value;
      csr_valid <= 1'b0;
   endtask

   task automatic check_field(input string name, input logic signed [RATE_W-1:0] want, got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, $signed(want), $signed(got));
         errors++;
      end
   endtask

   always @(posedge clock) begin
      rate_set_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rates.size() == 0) begin
            $error("response with no transaction outstanding");
            errors++;
         end else begin
            want = pending_rates.pop_front();
            check_field("rate_x", want.x, rsp_rate_x);
            check_field("rate_y", want.y, rsp_rate_y);
            check_field("rate_z", want.z, rsp_rate_z);
            check_field("read_failed", RATE_W'(want.failed), RATE_W'(rsp_read_failed));
         end
      end
   end

   // half full-range, some extremes and some close to the learned bias
   function automatic logic signed [SAMPLE_W-1:0] pick_raw(input longint bias_sum);
      int v;
      case ($urandom_range(0, 9))
         0: return RAW_MAX;
         1: return RAW_MIN;
         2, 3, 4: begin
            v = int'(bias_sum / CAL_SAMPLES) + $urandom_range(0, 400) - 200;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            return SAMPLE_W'(v);
         end
         default: return SAMPLE_W'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic pick_read_ok();
      return ($urandom_range(0, 7) == 0) ? READ_FAIL : READ_GOOD;
   endfunction

   task automatic test_calibration();
      longint tie_x;
      idle_odds  = 4;
      stall_odds = 4;
      for (int i = 0; i < CAL_SAMPLES; i++) begin
         if (i == 0) begin
            send_sample(READ_GOOD, RAW_MAX, RAW_MAX, RAW_MAX);
         end else if (i == 1) begin
            send_sample(READ_GOOD, RAW_MIN, RAW_MIN, RAW_MIN);
         end else if (i == 2) begin
            // failed reads must not touch the sums
            send_sample(READ_FAIL, RAW_MAX, RAW_MAX, RAW_MAX);
         end else if (i == 3) begin
            send_sample(READ_FAIL, RAW_MIN, RAW_MIN, RAW_MIN);
         end else if (i == CAL_SAMPLES - 1) begin
            // land sum_x on 50 mod N so unit sensitivity hits exact ties on x
            tie_x = ((50 - bias_x) % CAL_SAMPLES + CAL_SAMPLES) % CAL_SAMPLES;
            send_sample(READ_GOOD, SAMPLE_W'(tie_x), SAMPLE_W'($urandom_range(0, 65535)),
                        SAMPLE_W'($urandom_range(0, 65535)));
         end else begin
            send_sample(pick_read_ok(), SAMPLE_W'($urandom_range(0, 65535)),
                        SAMPLE_W'($urandom_range(0, 65535)), SAMPLE_W'($urandom_range(0, 65535)));
         end
      end
      settle();
   endtask

   // runs at the reset sensitivity, back to back
   task automatic test_extremes();
      idle_odds  = 0;
      stall_odds = 0;
      send_sample(READ_GOOD, RAW_MAX, RAW_MAX, RAW_MAX);
      send_sample(READ_GOOD, RAW_MIN, RAW_MIN, RAW_MIN);
      send_sample(READ_GOOD, 16'sd0, 16'sd0, 16'sd0);
      send_sample(READ_GOOD, -16'sd1, 16'sd1, -16'sd1);
      send_sample(READ_FAIL, RAW_MAX, RAW_MAX, RAW_MAX);
      send_sample(READ_FAIL, RAW_MIN, RAW_MIN, RAW_MIN);
      send_sample(READ_FAIL, 16'sd0, 16'sd0, 16'sd0);
      send_sample(READ_GOOD, RAW_MAX, RAW_MIN, 16'sd0);
      settle();
   endtask

   task automatic test_sensitivity_sweep();
      logic [SENS_W-1:0] sweep[8] = '{10'd0, 10'd1, 10'd1023, 10'd1000, 10'd512,
                                      10'd2, 10'd3, SENS_RESET};
      idle_odds  = 3;
      stall_odds = 3;
      foreach (sweep[i]) begin
         write_sensitivity(sweep[i]);
         send_sample(READ_GOOD, RAW_MAX, RAW_MIN, RAW_MAX);
         send_sample(READ_GOOD, RAW_MIN, RAW_MAX, RAW_MIN);
      end
      settle();
   endtask

   task automatic test_random();
      logic [SENS_W-1:0] sens;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: sens = 10'd1023;
            1: sens = 10'd0;
            2: sens = 10'd1;
            3: sens = 10'd1000;
            default: sens = ($urandom_range(0, 5) == 0) ? SENS_W'($urandom_range(1001, 1023))
                                                        : SENS_W'($urandom_range(1, 1000));
         endcase
         write_sensitivity(sens);
         if (p >= RANDOM_PHASES - 3) begin
            idle_odds  = 0;
            stall_odds = 0;
         end else begin
            idle_odds  = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(2, 8);
            stall_odds = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(2, 8);
         end
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            send_sample(pick_read_ok(), pick_raw(bias_x), pick_raw(bias_y), pick_raw(bias_z));
         end
      end
      settle();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_calibration();
      test_extremes();
      test_sensitivity_sweep();
      test_random();
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/gbcs_pkg.sv
rtl/gbcs_ctrl.sv
rtl/gbcs_datapath.sv
rtl/gyro_bias_calibrate_and_scale.sv
tb/sv/tb_gyro_bias_calibrate_and_scale.sv
